// ===== rtl/isoe_pkg.sv =====
package isoe_pkg;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned SecWidth   = 39;

  // Bounds of the seconds value for years 0000 through 9999 with any offset.
  localparam logic signed [SecWidth-1:0] SecMin = -39'sd62167305540;
  localparam logic signed [SecWidth-1:0] SecMax = 39'sd253402387139;

  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChDash  = 8'h2D;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChColon = 8'h3A;
  localparam logic [7:0] ChTee   = 8'h54;
  localparam logic [7:0] ChZulu  = 8'h5A;

  localparam logic [4:0] LenZulu    = 5'd20;
  localparam logic [4:0] LenCompact = 5'd24;
  localparam logic [4:0] LenColon   = 5'd25;
  localparam logic [4:0] PosMax     = 5'd31;

  // One parsed timestamp. The year is kept as century and year of century.
  typedef struct packed {
    logic       fmt_ok;
    logic       zone;
    logic       neg;
    logic [6:0] century;
    logic [6:0] yy;
    logic [6:0] month;
    logic [6:0] day;
    logic [6:0] hour;
    logic [6:0] minute;
    logic [6:0] second;
    logic [6:0] off_hour;
    logic [6:0] off_minute;
  } isoe_rec_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == ChSpace) || ((c >= ChTab) && (c <= ChCr));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= ChZero) && (c <= ChNine);
  endfunction

  // Accumulates one decimal digit; the value before is at most 9.
  function automatic logic [6:0] dec_acc(input logic [6:0] v, input logic [7:0] c);
    logic [7:0] dig;
    dig = c - ChZero;
    return 7'(v * 7'd10) + dig[6:0];
  endfunction

  function automatic logic [4:0] month_len(input logic [6:0] month, input logic leap);
    logic [4:0] len;
    unique case (month)
      7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10, 7'd12: len = 5'd31;
      7'd4, 7'd6, 7'd9, 7'd11:                    len = 5'd30;
      7'd2:                                       len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  // Days from March 1 to the first of the month, in a year that starts in March.
  function automatic logic [8:0] march_offset(input logic [6:0] month);
    logic [8:0] days;
    unique case (month)
      7'd3:    days = 9'd0;
      7'd4:    days = 9'd31;
      7'd5:    days = 9'd61;
      7'd6:    days = 9'd92;
      7'd7:    days = 9'd122;
      7'd8:    days = 9'd153;
      7'd9:    days = 9'd184;
      7'd10:   days = 9'd214;
      7'd11:   days = 9'd245;
      7'd12:   days = 9'd275;
      7'd1:    days = 9'd306;
      7'd2:    days = 9'd337;
      default: days = 9'd0;
    endcase
    return days;
  endfunction

endpackage

// ===== rtl/isoe_in_if.sv =====
interface isoe_in_if ();
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       is_final;

  modport source (output valid, char_in, is_final, input ready);
  modport sink (input valid, char_in, is_final, output ready);
endinterface

// ===== rtl/isoe_out_if.sv =====
interface isoe_out_if import isoe_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic                       ok;
  logic signed [SecWidth-1:0] epoch_seconds;

  modport source (output valid, ok, epoch_seconds, input ready);
  modport sink (input valid, ok, epoch_seconds, output ready);
endinterface

// ===== rtl/iso_timestamp_to_epoch_seconds.sv =====
// Converts an RFC 3339 style timestamp, fed one byte per word, into Unix seconds.
// The parser takes one byte every clock cycle and keeps accepting bytes while
// earlier strings are still being converted; it stalls only when the queue of
// finished strings is full. The conversion unit works in three steps (date to
// day of era, day of era to day count, day count to seconds with the offset
// applied) and takes the next string from the queue only once the result word
// of the last one is registered. Whitespace around the text is ignored; a result
// with ok low carries zero seconds.
module iso_timestamp_to_epoch_seconds import isoe_pkg::*; #(
  parameter int unsigned QDepth = QueueDepth
) (
  input logic         clk_i,
  input logic         rst_ni,
  isoe_in_if.sink     in_i,
  isoe_out_if.source  out_o
);

  logic      accept, push, full, empty, pop;
  isoe_rec_t push_rec, head_rec;

  assign in_i.ready = !full;
  assign accept     = in_i.valid && !full;

  isoe_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .char_in_i  (in_i.char_in),
    .is_final_i (in_i.is_final),
    .push_o     (push),
    .rec_o      (push_rec)
  );

  isoe_fifo #(
    .Depth (QDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .rec_i   (push_rec),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .rec_o   (head_rec)
  );

  isoe_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .rec_i       (head_rec),
    .pop_o       (pop),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .ok_o        (out_o.ok),
    .secs_o      (out_o.epoch_seconds)
  );

endmodule

// ===== rtl/isoe_front.sv =====
module isoe_front import isoe_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] char_in_i,
  input  logic       is_final_i,
  output logic       push_o,
  output isoe_rec_t  rec_o
);

  typedef enum logic [1:0] {PhLead, PhText, PhTrail} phase_e;

  phase_e     phase_q, phase_d;
  logic [4:0] pos_q, pos_d;
  logic [6:0] cent_q, cent_d, yy_q, yy_d, mon_q, mon_d, day_q, day_d;
  logic [6:0] hr_q, hr_d, min_q, min_d, sec_q, sec_d, oh_q, oh_d, om_q, om_d;
  logic       neg_q, neg_d, zone_q, zone_d, fail_q, fail_d, colon_q, colon_d;
  logic       take, dig, shape_ok;

  always_comb begin
    phase_d = phase_q;
    pos_d   = pos_q;
    cent_d  = cent_q;
    yy_d    = yy_q;
    mon_d   = mon_q;
    day_d   = day_q;
    hr_d    = hr_q;
    min_d   = min_q;
    sec_d   = sec_q;
    oh_d    = oh_q;
    om_d    = om_q;
    neg_d   = neg_q;
    zone_d  = zone_q;
    fail_d  = fail_q;
    colon_d = colon_q;
    take    = 1'b0;
    dig     = is_digit(char_in_i);

    if (is_ws(char_in_i)) begin
      if (phase_q == PhText) phase_d = PhTrail;
    end else if (phase_q != PhTrail) begin
      phase_d = PhText;
      take    = 1'b1;
    end else begin
      // Text after trailing whitespace means whitespace inside the text.
      fail_d = 1'b1;
    end

    if (take) begin
      unique case (pos_q)
        5'd0, 5'd1: begin
          if (dig) cent_d = dec_acc(cent_q, char_in_i); else fail_d = 1'b1;
        end
        5'd2, 5'd3: begin
          if (dig) yy_d = dec_acc(yy_q, char_in_i); else fail_d = 1'b1;
        end
        5'd4, 5'd7: begin
          if (char_in_i != ChDash) fail_d = 1'b1;
        end
        5'd5, 5'd6: begin
          if (dig) mon_d = dec_acc(mon_q, char_in_i); else fail_d = 1'b1;
        end
        5'd8, 5'd9: begin
          if (dig) day_d = dec_acc(day_q, char_in_i); else fail_d = 1'b1;
        end
        5'd10: begin
          if (char_in_i != ChTee) fail_d = 1'b1;
        end
        5'd11, 5'd12: begin
          if (dig) hr_d = dec_acc(hr_q, char_in_i); else fail_d = 1'b1;
        end
        5'd13, 5'd16: begin
          if (char_in_i != ChColon) fail_d = 1'b1;
        end
        5'd14, 5'd15: begin
          if (dig) min_d = dec_acc(min_q, char_in_i); else fail_d = 1'b1;
        end
        5'd17, 5'd18: begin
          if (dig) sec_d = dec_acc(sec_q, char_in_i); else fail_d = 1'b1;
        end
        5'd19: begin
          if (char_in_i == ChZulu) zone_d = 1'b1;
          else if (char_in_i == ChDash) neg_d = 1'b1;
          else if (char_in_i != ChPlus) fail_d = 1'b1;
        end
        5'd20, 5'd21: begin
          if (dig) oh_d = dec_acc(oh_q, char_in_i); else fail_d = 1'b1;
        end
        5'd22: begin
          if (char_in_i == ChColon) colon_d = 1'b1;
          else if (dig) om_d = dec_acc(om_q, char_in_i);
          else fail_d = 1'b1;
        end
        5'd23: begin
          if (dig) om_d = dec_acc(om_q, char_in_i); else fail_d = 1'b1;
        end
        5'd24: begin
          if (!colon_q) fail_d = 1'b1;
          else if (dig) om_d = dec_acc(om_q, char_in_i);
          else fail_d = 1'b1;
        end
        default: fail_d = 1'b1;
      endcase
      if (pos_q != PosMax) pos_d = pos_q + 5'd1;
    end
  end

  assign shape_ok = zone_d ? (pos_d == LenZulu)
                           : (((pos_d == LenCompact) && !colon_d) ||
                              ((pos_d == LenColon) && colon_d));

  always_comb begin
    rec_o.fmt_ok     = !fail_d && shape_ok;
    rec_o.zone       = zone_d;
    rec_o.neg        = neg_d;
    rec_o.century    = cent_d;
    rec_o.yy         = yy_d;
    rec_o.month      = mon_d;
    rec_o.day        = day_d;
    rec_o.hour       = hr_d;
    rec_o.minute     = min_d;
    rec_o.second     = sec_d;
    rec_o.off_hour   = oh_d;
    rec_o.off_minute = om_d;
  end

  assign push_o = accept_i && is_final_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhLead;
      pos_q   <= '0;
      cent_q  <= '0;
      yy_q    <= '0;
      mon_q   <= '0;
      day_q   <= '0;
      hr_q    <= '0;
      min_q   <= '0;
      sec_q   <= '0;
      oh_q    <= '0;
      om_q    <= '0;
      neg_q   <= 1'b0;
      zone_q  <= 1'b0;
      fail_q  <= 1'b0;
      colon_q <= 1'b0;
    end else if (accept_i && is_final_i) begin
      phase_q <= PhLead;
      pos_q   <= '0;
      cent_q  <= '0;
      yy_q    <= '0;
      mon_q   <= '0;
      day_q   <= '0;
      hr_q    <= '0;
      min_q   <= '0;
      sec_q   <= '0;
      oh_q    <= '0;
      om_q    <= '0;
      neg_q   <= 1'b0;
      zone_q  <= 1'b0;
      fail_q  <= 1'b0;
      colon_q <= 1'b0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      cent_q  <= cent_d;
      yy_q    <= yy_d;
      mon_q   <= mon_d;
      day_q   <= day_d;
      hr_q    <= hr_d;
      min_q   <= min_d;
      sec_q   <= sec_d;
      oh_q    <= oh_d;
      om_q    <= om_d;
      neg_q   <= neg_d;
      zone_q  <= zone_d;
      fail_q  <= fail_d;
      colon_q <= colon_d;
    end
  end

endmodule

// ===== rtl/isoe_fifo.sv =====
module isoe_fifo import isoe_pkg::*; #(
  parameter int unsigned Depth = QueueDepth
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  isoe_rec_t rec_i,
  output logic      full_o,
  input  logic      pop_i,
  output logic      empty_o,
  output isoe_rec_t rec_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  isoe_rec_t       mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign rec_o   = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= rec_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      if (pop_i) rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      if (push_i && !pop_i) cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

// ===== rtl/isoe_back.sv =====
module isoe_back import isoe_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       empty_i,
  input  isoe_rec_t                  rec_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic                       ok_o,
  output logic signed [SecWidth-1:0] secs_o
);

  typedef enum logic [1:0] {BIdle, BDays, BSecs} bstate_e;

  bstate_e state_q;

  // Date stage, worked out from the head of the queue.
  logic              adj, borrow, leap, ok_d;
  logic signed [7:0] cent_adj;
  logic [6:0]        yy_adj;
  logic [1:0]        m4;
  logic [8:0]        yoe;
  logic [17:0]       doe_d;
  logic [12:0]       hm_d, ohm_d;

  logic              ok_q, neg_q;
  logic signed [5:0] era_q;
  logic [17:0]       doe_q;
  logic [12:0]       hm_q, ohm_q;
  logic [6:0]        sec_q;

  logic signed [23:0] days_d, days_q;
  logic [18:0]        tod_d, tod_q, offs_d, offs_q;
  logic signed [39:0] base, total;

  logic               out_valid_q, out_ok_q, emit;
  logic signed [SecWidth-1:0] out_secs_q;

  always_comb begin
    // The civil year starts in March, so January and February count with the year before.
    adj      = (rec_i.month <= 7'd2);
    borrow   = adj && (rec_i.yy == 7'd0);
    cent_adj = 8'(rec_i.century) - 8'(borrow);
    if (!adj) yy_adj = rec_i.yy;
    else if (rec_i.yy == 7'd0) yy_adj = 7'd99;
    else yy_adj = rec_i.yy - 7'd1;
    m4  = cent_adj[1:0];
    yoe = 9'(m4) * 9'd100 + 9'(yy_adj);
    doe_d = 18'(yoe) * 18'd365 + 18'(m4) * 18'd24 + 18'(yy_adj[6:2])
          + 18'(march_offset(rec_i.month)) + 18'(rec_i.day) - 18'd1;

    leap = (rec_i.yy == 7'd0) ? (rec_i.century[1:0] == 2'd0) : (rec_i.yy[1:0] == 2'd0);
    ok_d = rec_i.fmt_ok && (rec_i.month >= 7'd1) && (rec_i.month <= 7'd12) &&
           (rec_i.day >= 7'd1) && (rec_i.day <= 7'(month_len(rec_i.month, leap))) &&
           (rec_i.hour <= 7'd23) && (rec_i.minute <= 7'd59) && (rec_i.second <= 7'd59) &&
           (rec_i.zone || ((rec_i.off_hour <= 7'd23) && (rec_i.off_minute <= 7'd59)));

    hm_d  = 13'(rec_i.hour) * 13'd60 + 13'(rec_i.minute);
    ohm_d = rec_i.zone ? 13'd0 : 13'(rec_i.off_hour) * 13'd60 + 13'(rec_i.off_minute);
  end

  always_comb begin
    days_d = 24'($signed(era_q) * 24'sd146097) + $signed({6'b0, doe_q}) - 24'sd719468;
    tod_d  = 19'(hm_q) * 19'd60 + 19'(sec_q);
    offs_d = 19'(ohm_q) * 19'd60;
  end

  always_comb begin
    base  = 40'($signed(days_q) * 40'sd86400) + $signed({21'b0, tod_q});
    total = neg_q ? base + $signed({21'b0, offs_q}) : base - $signed({21'b0, offs_q});
  end

  assign pop_o = (state_q == BIdle) && !empty_i;
  assign emit  = (state_q == BSecs) && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      ok_q  <= ok_d;
      neg_q <= rec_i.neg;
      era_q <= cent_adj[7:2];
      doe_q <= doe_d;
      hm_q  <= hm_d;
      sec_q <= rec_i.second;
      ohm_q <= ohm_d;
    end
    if (state_q == BDays) begin
      days_q <= days_d;
      tod_q  <= tod_d;
      offs_q <= offs_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BIdle;
      out_valid_q <= 1'b0;
      out_ok_q    <= 1'b0;
      out_secs_q  <= '0;
    end else begin
      if (emit) begin
        out_valid_q <= 1'b1;
        out_ok_q    <= ok_q;
        out_secs_q  <= ok_q ? total[SecWidth-1:0] : '0;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        BIdle: begin
          if (!empty_i) state_q <= BDays;
        end
        BDays: state_q <= BSecs;
        BSecs: begin
          if (emit) state_q <= BIdle;
        end
        default: state_q <= BIdle;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign ok_o        = out_ok_q;
  assign secs_o      = out_secs_q;

endmodule

// ===== rtl/isoe_checker.sv =====
module isoe_checker import isoe_pkg::*; (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_i,
  input logic                       is_final_i,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic                       ok_i,
  input logic signed [SecWidth-1:0] epoch_seconds_i
);

  // Strings whose final byte went in and whose result has not been taken yet.
  logic [2:0] pending_q;
  logic       fin_in, res_out;

  assign fin_in  = in_valid_i && in_ready_i && is_final_i;
  assign res_out = out_valid_i && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else if (fin_in && !res_out) begin
      pending_q <= pending_q + 3'd1;
    end else if (res_out && !fin_in) begin
      pending_q <= pending_q - 3'd1;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(ok_i) && $stable(epoch_seconds_i))
    else $error("result word changed while stalled");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !ok_i |-> epoch_seconds_i == '0)
    else $error("failed parse carries nonzero seconds");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && ok_i |-> (epoch_seconds_i >= SecMin) && (epoch_seconds_i <= SecMax))
    else $error("seconds outside the range of valid timestamps");

  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> pending_q != 3'd0)
    else $error("result word without a string behind it");

endmodule

bind iso_timestamp_to_epoch_seconds isoe_checker u_isoe_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_i.valid),
  .in_ready_i      (in_i.ready),
  .is_final_i      (in_i.is_final),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .ok_i            (out_o.ok),
  .epoch_seconds_i (out_o.epoch_seconds)
);

// ===== tb/tb_iso_timestamp_to_epoch_seconds.sv =====
module tb_iso_timestamp_to_epoch_seconds;
  import isoe_pkg::*;

  typedef enum logic [1:0] {PhLead, PhText, PhTrail} text_phase_e;
  typedef enum int {ZoneZulu, ZoneCompact, ZoneColon} zone_form_e;
  typedef logic [7:0] str_t[$];

  typedef struct {
    bit                  ok;
    logic [SecWidth-1:0] secs;
  } stamp_result_t;

  localparam logic [7:0] WsSet [6] = '{ChSpace, ChTab, 8'h0A, 8'h0B, 8'h0C, ChCr};
  localparam int ItemTarget = 1550;
  localparam int DrainLimit = 20000;

  function automatic int month_length(longint y, longint m);
    bit leap;
    leap = (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    case (m)
      1, 3, 5, 7, 8, 10, 12: return 31;
      4, 6, 9, 11:           return 30;
      2:                     return leap ? 29 : 28;
      default:               return 0;
    endcase
  endfunction

  // Days since 1970-01-01, counting in 400-year cycles of a year that starts in March.
  function automatic longint day_number(longint year, longint month, longint day);
    longint sy, cyc, yoc, mi, doy, doc;
    sy = year;
    if (month <= 2) sy = sy - 1;
    cyc = (sy >= 0 ? sy : sy - 399) / 400;
    yoc = sy - cyc * 400;
    mi = (month > 2) ? month - 3 : month + 9;
    doy = (153 * mi + 2) / 5 + day - 1;
    doc = yoc * 365 + yoc / 4 - yoc / 100 + doy;
    return cyc * 146097 + doc - 719468;
  endfunction

  function automatic bit is_space(logic [7:0] c);
    return (c == ChSpace) || (c >= ChTab && c <= ChCr);
  endfunction

  function automatic bit is_num(logic [7:0] c);
    return c >= ChZero && c <= ChNine;
  endfunction

  class stamp_predictor;
    text_phase_e   phase;
    bit [4:0]      pos;
    bit [13:0]     yr;
    bit [6:0]      mon, dy, hr, mn, se, ohr, omn;
    bit            neg, zulu, bad, colon;
    stamp_result_t expected_secs[$];
    int            errors, strings, valid_count, checked;

    function new();
      clear();
    endfunction

    function void clear();
      phase = PhLead;
      pos = '0;
      yr = '0;
      {mon, dy, hr, mn, se, ohr, omn} = '0;
      {neg, zulu, bad, colon} = '0;
    endfunction

    function bit digit_ok(logic [7:0] c);
      if (!is_num(c)) bad = 1'b1;
      return is_num(c);
    endfunction

    function bit [6:0] acc(bit [6:0] v, logic [7:0] c);
      return 7'(v * 10 + (c - ChZero));
    endfunction

    function void take_text(logic [7:0] c);
      if (pos <= 3) begin
        if (digit_ok(c)) yr = 14'(yr * 10 + (c - ChZero));
      end else if (pos == 4 || pos == 7) begin
        if (c != ChDash) bad = 1'b1;
      end else if (pos == 5 || pos == 6) begin
        if (digit_ok(c)) mon = acc(mon, c);
      end else if (pos == 8 || pos == 9) begin
        if (digit_ok(c)) dy = acc(dy, c);
      end else if (pos == 10) begin
        if (c != ChTee) bad = 1'b1;
      end else if (pos == 11 || pos == 12) begin
        if (digit_ok(c)) hr = acc(hr, c);
      end else if (pos == 13 || pos == 16) begin
        if (c != ChColon) bad = 1'b1;
      end else if (pos == 14 || pos == 15) begin
        if (digit_ok(c)) mn = acc(mn, c);
      end else if (pos == 17 || pos == 18) begin
        if (digit_ok(c)) se = acc(se, c);
      end else if (pos == 19) begin
        if (c == ChZulu) zulu = 1'b1;
        else if (c == ChDash) neg = 1'b1;
        else if (c != ChPlus) bad = 1'b1;
      end else if (pos == 20 || pos == 21) begin
        if (digit_ok(c)) ohr = acc(ohr, c);
      end else if (pos == 22) begin
        if (c == ChColon) colon = 1'b1;
        else if (digit_ok(c)) omn = acc(omn, c);
      end else if (pos == 23) begin
        if (digit_ok(c)) omn = acc(omn, c);
      end else if (pos == 24) begin
        if (!colon) bad = 1'b1;
        else if (digit_ok(c)) omn = acc(omn, c);
      end else begin
        bad = 1'b1;
      end
      if (pos < PosMax) pos++;
    endfunction

    function void close_string();
      stamp_result_t r;
      longint        t, off;
      bit            shape;
      r.ok = 1'b0;
      r.secs = '0;
      shape = zulu ? (pos == LenZulu)
                   : ((pos == LenCompact && !colon) || (pos == LenColon && colon));
      if (!bad && shape && yr <= 9999 && mon >= 1 && mon <= 12 && dy >= 1
          && dy <= month_length(yr, mon) && hr <= 23 && mn <= 59 && se <= 59
          && (zulu || (ohr <= 23 && omn <= 59))) begin
        t = day_number(yr, mon, dy) * 86400 + longint'(hr) * 3600
            + longint'(mn) * 60 + longint'(se);
        if (!zulu) begin
          off = (longint'(ohr) * 60 + longint'(omn)) * 60;
          t = neg ? t + off : t - off;
        end
        r.ok = 1'b1;
        r.secs = t[SecWidth-1:0];
      end
      expected_secs.push_back(r);
      strings++;
      if (r.ok) valid_count++;
      clear();
    endfunction

    function void take_char(logic [7:0] c, bit fin);
      if (is_space(c)) begin
        if (phase == PhText) phase = PhTrail;
      end else begin
        if (phase == PhLead) phase = PhText;
        if (phase == PhText) take_text(c);
        else bad = 1'b1;
      end
      if (fin) close_string();
    endfunction

    task flag_mismatch(string msg);
      errors++;
      if (errors <= 40) $display("MISMATCH at %0t: %s", $realtime, msg);
    endtask

    task compare_result(bit ok, logic [SecWidth-1:0] secs);
      stamp_result_t e;
      if (expected_secs.size() == 0) begin
        flag_mismatch($sformatf("result ok=%0b secs=%0d with nothing expected",
                                ok, $signed(secs)));
        return;
      end
      e = expected_secs.pop_front();
      checked++;
      if (ok !== e.ok)
        flag_mismatch($sformatf("string %0d: ok %0b, expected %0b", checked, ok, e.ok));
      if (secs !== e.secs)
        flag_mismatch($sformatf("string %0d: seconds %0d, expected %0d", checked,
                                $signed(secs), $signed(e.secs)));
    endtask
  endclass

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  bit   calm   = 1'b0;
  int   text_chars = 0;
  int   item_count = 0;

  stamp_predictor sb = new();

  isoe_in_if  in_if ();
  isoe_out_if out_if ();

  iso_timestamp_to_epoch_seconds dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  initial begin
    in_if.valid    = 1'b0;
    in_if.char_in  = '0;
    in_if.is_final = 1'b0;
    out_if.ready   = 1'b0;
  end

  always @(posedge clk_i) begin
    out_if.ready <= calm || ($urandom_range(99) >= 9);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready)
      sb.compare_result(out_if.ok, out_if.epoch_seconds);
  end

  task send_char(logic [7:0] c, bit fin);
    while (!calm && $urandom_range(99) < 9) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid    <= 1'b1;
    in_if.char_in  <= c;
    in_if.is_final <= fin;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    sb.take_char(c, fin);
    item_count++;
    if (!is_space(c)) text_chars++;
  endtask

  task send_text(str_t s);
    foreach (s[i]) send_char(s[i], i == s.size() - 1);
  endtask

  task wait_drained();
    in_if.valid <= 1'b0;
    while (sb.expected_secs.size() != 0) @(posedge clk_i);
  endtask

  function automatic void put_num(ref str_t s, input int v, input int digits);
    int p;
    p = 1;
    for (int j = 1; j < digits; j++) p *= 10;
    for (int j = 0; j < digits; j++) begin
      s.push_back(8'(ChZero + (v / p) % 10));
      p /= 10;
    end
  endfunction

  function automatic str_t make_stamp(int y, int mo, int d, int h, int mi, int sec,
                                      zone_form_e zf, bit neg, int oh, int om);
    str_t s;
    put_num(s, y, 4);
    s.push_back(ChDash);
    put_num(s, mo, 2);
    s.push_back(ChDash);
    put_num(s, d, 2);
    s.push_back(ChTee);
    put_num(s, h, 2);
    s.push_back(ChColon);
    put_num(s, mi, 2);
    s.push_back(ChColon);
    put_num(s, sec, 2);
    if (zf == ZoneZulu) begin
      s.push_back(ChZulu);
    end else begin
      s.push_back(neg ? ChDash : ChPlus);
      put_num(s, oh, 2);
      if (zf == ZoneColon) s.push_back(ChColon);
      put_num(s, om, 2);
    end
    return s;
  endfunction

  function automatic str_t text(string lit);
    str_t s;
    for (int i = 0; i < lit.len(); i++) s.push_back(lit[i]);
    return s;
  endfunction

  function automatic void wrap_ws(ref str_t s, input int lead, input int trail);
    repeat (lead) s.push_front(WsSet[$urandom_range(5)]);
    repeat (trail) s.push_back(WsSet[$urandom_range(5)]);
  endfunction

  // Mostly in range, now and then just past the edge or far out.
  function automatic int pick_field(int hi, int top);
    int r;
    r = $urandom_range(99);
    if (r < 4) return hi + 1;
    if (r < 7) return $urandom_range(top, hi + 1);
    if (r < 15) return hi;
    return $urandom_range(hi, 0);
  endfunction

  function automatic str_t random_stamp();
    int y, mo, d, dim;
    case ($urandom_range(9))
      0:       y = 0;
      1:       y = 9999;
      2:       y = 4 * $urandom_range(2499, 0);
      3:       y = 100 * $urandom_range(99, 0);
      default: y = $urandom_range(9999, 0);
    endcase
    mo = ($urandom_range(99) < 6) ? ($urandom_range(1) ? 0 : $urandom_range(99, 13))
                                  : $urandom_range(12, 1);
    dim = month_length(y, mo);
    if (dim == 0) dim = 28;
    case ($urandom_range(19))
      0:       d = 0;
      1:       d = dim + 1;
      2:       d = $urandom_range(99, 29);
      3, 4:    d = dim;
      default: d = $urandom_range(dim, 1);
    endcase
    return make_stamp(y, mo, d, pick_field(23, 99), pick_field(59, 99), pick_field(59, 99),
                      zone_form_e'($urandom_range(2)), $urandom_range(1),
                      pick_field(23, 99), pick_field(59, 99));
  endfunction

  function automatic void corrupt(ref str_t s);
    int at;
    at = $urandom_range(s.size() - 1);
    case ($urandom_range(7))
      0: s[at] = 8'($urandom_range(255));
      1: s.delete(at);
      2: s.insert(at, 8'($urandom_range(255)));
      3: s.insert($urandom_range(s.size() - 1, 1), WsSet[$urandom_range(5)]);
      4: repeat ($urandom_range(15, 1)) s.push_back(8'(ChZero + $urandom_range(9)));
      5: s[$urandom_range(3)] = $urandom_range(1) ? ChPlus : ChDash;
      6: begin
        s.delete();
        repeat ($urandom_range(40, 1)) s.push_back(8'($urandom_range(255)));
      end
      default: s.delete();
    endcase
  endfunction

  task run_directed();
    str_t s;
    send_text(text("1970-01-01T00:00:00Z"));
    send_text(text("0000-01-01T00:00:00+23:59"));
    send_text(text("9999-12-31T23:59:59-23:59"));
    send_text(text("2000-02-29T12:34:56+0530"));
    send_text(text("1900-02-29T00:00:00Z"));
    send_text(text("2024-02-29T23:59:59-08:00"));
    send_text(text("2023-02-29T00:00:00Z"));
    send_text(text("2021-00-10T00:00:00Z"));
    send_text(text("2021-13-10T00:00:00Z"));
    send_text(text("2021-04-31T00:00:00Z"));
    send_text(text("2021-01-00T24:60:60Z"));
    send_text(text("2021-01-05T10:00:00+24:60"));
    s = text("1969-12-31T23:59:59-0000");
    foreach (WsSet[i]) begin
      s.push_front(WsSet[i]);
      s.push_back(WsSet[i]);
    end
    send_text(s);
    // A space between date and time leaves text after the trailing whitespace.
    send_text(text("1970-01-01 00:00:00Z"));
    send_text(text(" \t  "));
    send_text(text("1970-01-01T00:00:00Z00000000000000000000"));
    send_text(text("+970-01-01T00:00:00Z"));
    send_text(text("1970-01-01T00:00:00X"));
    send_text(text("1970-01-01T00:00:00Z0000"));
    send_text(text("1970-01-01T00:00:00+"));
    send_text(text("1970-01-01T00:00:00+05:0"));
    send_text(text("1970-01-01T00:00:00+05000"));
    send_text(text("Z"));
    send_text({8'hFF, 8'h80, 8'h7F});
  endtask

  initial begin
    str_t s;
    int   n;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();
    // Hold the sender until the converter has emptied, then go on.
    wait_drained();

    n = 0;
    while (item_count < ItemTarget) begin
      s = random_stamp();
      if ($urandom_range(99) < 25) corrupt(s);
      wrap_ws(s, ($urandom_range(3) == 0) ? $urandom_range(3, 1) : 0,
              ($urandom_range(3) == 0) ? $urandom_range(3, 1) : 0);
      if (s.size() == 0) s.push_back(ChSpace);
      calm = (n >= 20 && n < 35);
      if (n == 45) wait_drained();
      send_text(s);
      n++;
    end
    calm = 1'b0;
    in_if.valid <= 1'b0;

    n = 0;
    while (sb.expected_secs.size() != 0 && n < DrainLimit) begin
      @(posedge clk_i);
      n++;
    end
    repeat (10) @(posedge clk_i);
    while (sb.expected_secs.size() != 0) begin
      void'(sb.expected_secs.pop_front());
      sb.flag_mismatch("expected result never arrived");
    end

    $display("Converted %0d timestamp strings (%0d valid dates, %0d checked results)",
             sb.strings, sb.valid_count, sb.checked);
    $display("from %0d bytes (%0d outside whitespace), with stalls on both sides.",
             item_count, text_chars);
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
